@@ hw/rtl/dfsr_pkg.sv @@
package dfsr_pkg;

  localparam int PAYLOAD_LEN = 12;
  localparam int IDX_W = $clog2(PAYLOAD_LEN + 1);
  localparam int WORD_W = 32;
  localparam int LOST_OUT_W = 16;
  localparam int LOST_COUNT_WIDTH_DEF = 16;

  localparam logic [7:0] HDR_BOX = 8'hB6;
  localparam logic [7:0] HDR_LASER = 8'hA5;
  localparam logic [7:0] TAIL_BOX = 8'h6B;
  localparam logic [7:0] TAIL_LASER = 8'h5A;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_TAIL
  } phase_t;

  typedef struct packed {
    logic              laser;
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] k;
  } frame_t;

  typedef struct packed {
    logic   fire;
    frame_t frame;
  } evt_t;

endpackage

@@ hw/rtl/dfsr_parser.sv @@
module dfsr_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic [7:0]    byte_in,
  output dfsr_pkg::evt_t evt
);
  import dfsr_pkg::*;

  phase_t           phase;
  phase_t           phase_next;
  logic             laser;
  logic             laser_next;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] idx_next;
  logic             wr_en;
  logic             good;
  logic [7:0]       store [PAYLOAD_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      laser <= 1'b0;
      idx   <= '0;
    end else begin
      phase <= phase_next;
      laser <= laser_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[idx] <= byte_in;
    end
  end

  always_comb begin
    phase_next = phase;
    laser_next = laser;
    idx_next   = idx;
    wr_en      = 1'b0;
    good       = laser ? (byte_in == TAIL_LASER) : (byte_in == TAIL_BOX);
    evt.fire   = 1'b0;
    evt.frame.laser = laser;
    evt.frame.x = {store[3], store[2], store[1], store[0]};
    evt.frame.y = {store[7], store[6], store[5], store[4]};
    evt.frame.k = {store[11], store[10], store[9], store[8]};
    if (step) begin
      case (phase)
        PH_PAYLOAD: begin
          wr_en = (idx < IDX_W'(PAYLOAD_LEN));
          if (idx >= IDX_W'(PAYLOAD_LEN - 1)) begin
            phase_next = PH_TAIL;
            idx_next   = IDX_W'(PAYLOAD_LEN);
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
        PH_TAIL: begin
          phase_next = PH_IDLE;
          idx_next   = '0;
          evt.fire   = good;
        end
        default: begin
          if (byte_in == HDR_BOX) begin
            laser_next = 1'b0;
            phase_next = PH_PAYLOAD;
            idx_next   = '0;
          end else if (byte_in == HDR_LASER) begin
            laser_next = 1'b1;
            phase_next = PH_PAYLOAD;
            idx_next   = '0;
          end else begin
            phase_next = PH_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/dfsr_result.sv @@
module dfsr_result #(
  parameter int LOST_COUNT_WIDTH = dfsr_pkg::LOST_COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  dfsr_pkg::evt_t                  evt,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic                            frame_kind,
  output logic [dfsr_pkg::WORD_W-1:0]     word_first,
  output logic [dfsr_pkg::WORD_W-1:0]     word_second,
  output logic [dfsr_pkg::WORD_W-1:0]     word_third,
  output logic [dfsr_pkg::WORD_W-1:0]     previous_box_x,
  output logic [dfsr_pkg::LOST_OUT_W-1:0] lost_count
);
  import dfsr_pkg::*;

  logic [LOST_COUNT_WIDTH-1:0]            cnt;
  logic [LOST_COUNT_WIDTH-1:0]            cnt_next;
  logic [LOST_COUNT_WIDTH+LOST_OUT_W-1:0] cnt_wide;
  logic [WORD_W-1:0]                      box_x_last;
  logic                                   both_zero;
  logic                                   bump;

  // sign bit ignored for the zero test
  assign both_zero = (evt.frame.x[WORD_W-2:0] == '0) && (evt.frame.y[WORD_W-2:0] == '0);
  assign bump      = evt.fire && evt.frame.laser && both_zero && (cnt != '1);
  assign cnt_next  = bump ? cnt + LOST_COUNT_WIDTH'(1) : cnt;
  assign cnt_wide  = {{LOST_OUT_W{1'b0}}, cnt_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      box_x_last <= '0;
      out_valid  <= 1'b0;
    end else begin
      cnt <= cnt_next;
      if (evt.fire && !evt.frame.laser) begin
        box_x_last <= evt.frame.x;
      end
      if (evt.fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (evt.fire) begin
      frame_kind     <= evt.frame.laser;
      word_first     <= evt.frame.x;
      word_second    <= evt.frame.y;
      word_third     <= evt.frame.k;
      previous_box_x <= evt.frame.laser ? '0 : box_x_last;
      lost_count     <= cnt_wide[LOST_OUT_W-1:0];
    end
  end

endmodule

@@ hw/rtl/dual_frame_serial_receiver.sv @@
// dual_frame_serial_receiver
// parses a serial byte stream into box and laser coordinate frames
// input channel: rx_byte with in_valid / in_ready, one byte per transfer
// output channel: one result per good frame with out_valid / out_ready,
//   carrying frame_kind, the three payload words, previous_box_x and lost_count
// a frame is a header byte, 12 payload bytes and a tail byte; a bad tail
//   drops the frame with no result
// throughput: one byte per cycle unless a result waits on out_ready, set by
//   the single parse stage that sits between the input register and the
//   result register; a tail byte passes the input register and the parse
//   stage, and its result is then offered from the result register
// reset: parser returns to idle, lost counter and stored box x clear,
//   no result is offered
// stall: while a result waits on out_ready the input register holds its byte
//   and in_ready drops once it is full; bytes are never lost
module dual_frame_serial_receiver #(
  parameter int LOST_COUNT_WIDTH = dfsr_pkg::LOST_COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      rx_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            frame_kind,
  output logic [dfsr_pkg::WORD_W-1:0]     word_first,
  output logic [dfsr_pkg::WORD_W-1:0]     word_second,
  output logic [dfsr_pkg::WORD_W-1:0]     word_third,
  output logic [dfsr_pkg::WORD_W-1:0]     previous_box_x,
  output logic [dfsr_pkg::LOST_OUT_W-1:0] lost_count
);
  import dfsr_pkg::*;

  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       advance;
  evt_t       evt;

  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte <= rx_byte;
    end
  end

  dfsr_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (hold_byte),
    .evt     (evt)
  );

  dfsr_result #(
    .LOST_COUNT_WIDTH (LOST_COUNT_WIDTH)
  ) u_result (
    .clk            (clk),
    .rst            (rst),
    .evt            (evt),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .frame_kind     (frame_kind),
    .word_first     (word_first),
    .word_second    (word_second),
    .word_third     (word_third),
    .previous_box_x (previous_box_x),
    .lost_count     (lost_count)
  );

  a_fire_on_advance: assert property (@(posedge clk) disable iff (rst)
    evt.fire |-> advance)
    else $error("frame result raised without a parse step");

  a_result_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance))
    else $error("result appeared without a parse step");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    hold_valid && !advance |=> hold_valid && $stable(hold_byte))
    else $error("held byte lost during stall");

  a_box_prev: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) && frame_kind |-> previous_box_x == '0)
    else $error("laser result carries a box x");

endmodule

@@ tb/sv/dual_frame_serial_receiver_test.sv @@
`timescale 1ns / 1ps

module dual_frame_serial_receiver_test;
  import dfsr_pkg::*;

  localparam int LOST_W = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_BYTES = 1200;
  localparam int LOST_FRAMES = 10;
  localparam logic KIND_BOX = 1'b0;
  localparam logic KIND_LASER = 1'b1;

  typedef struct packed {
    logic                  kind;
    logic [WORD_W-1:0]     x;
    logic [WORD_W-1:0]     y;
    logic [WORD_W-1:0]     k;
    logic [WORD_W-1:0]     prev;
    logic [LOST_OUT_W-1:0] lost;
  } frame_result_t;

  typedef struct packed {
    logic [7:0]    lead;
    logic [7:0]    head;
    logic [95:0]   body;
    logic [7:0]    tail;
    logic          typed;
    logic          fires;
    frame_result_t want;
  } directed_frame_t;

  localparam directed_frame_t DIRECTED [10] = '{
    '{8'h00, HDR_BOX, {32'h12345678, 32'h00000000, 32'hFFFFFFFF}, TAIL_BOX, 1'b1, 1'b1,
      '{KIND_BOX, 32'hFFFFFFFF, 32'h00000000, 32'h12345678, 32'h00000000, 16'd0}},
    '{8'hFF, HDR_BOX, {32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000}, TAIL_BOX, 1'b1, 1'b1,
      '{KIND_BOX, 32'h00000000, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'd0}},
    '{8'h5A, HDR_LASER, {32'h00000000, 32'h00000000, 32'h00000000}, TAIL_LASER, 1'b1, 1'b1,
      '{KIND_LASER, 32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 16'd1}},
    '{8'h6B, HDR_LASER, {32'h7FFFFFFF, 32'h80000000, 32'h80000000}, TAIL_LASER, 1'b1, 1'b1,
      '{KIND_LASER, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h00000000, 16'd2}},
    '{8'h01, HDR_LASER, {32'h00000000, 32'h00000000, 32'h00000001}, TAIL_LASER, 1'b1, 1'b1,
      '{KIND_LASER, 32'h00000001, 32'h00000000, 32'h00000000, 32'h00000000, 16'd2}},
    '{8'h80, HDR_BOX, {32'h6B5A6B5A, 32'hA5A5B6B6, 32'hB6B6A5A5}, TAIL_LASER, 1'b1, 1'b0,
      '0},
    '{8'h7F, HDR_LASER, {32'h00000000, 32'h00000000, 32'h00000000}, TAIL_BOX, 1'b1, 1'b0,
      '0},
    '{8'h55, HDR_BOX, {32'h01020304, 32'h05060708, 32'h090A0B0C}, HDR_BOX, 1'b1, 1'b0,
      '0},
    '{8'hAA, HDR_BOX, {32'hC0490FDB, 32'h40000000, 32'h3F800000}, TAIL_BOX, 1'b0, 1'b0,
      '0},
    '{8'h00, HDR_LASER, {32'h00000001, 32'h7FFFFFFF, 32'h00000000}, TAIL_LASER, 1'b0, 1'b0,
      '0}
  };

  localparam int SEND_IDLE [4] = '{0, 48, 0, 20};
  localparam int RECV_STALL [4] = '{0, 0, 48, 20};

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic [7:0]            rx_byte;
  logic                  out_valid;
  logic                  out_ready;
  logic                  frame_kind;
  logic [WORD_W-1:0]     word_first;
  logic [WORD_W-1:0]     word_second;
  logic [WORD_W-1:0]     word_third;
  logic [WORD_W-1:0]     previous_box_x;
  logic [LOST_OUT_W-1:0] lost_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int frame_bytes = 0;
  int box_seen = 0;
  int laser_seen = 0;

  phase_t            prs_phase;
  logic              prs_laser;
  logic [3:0]        prs_slot;
  logic [7:0]        prs_payload [PAYLOAD_LEN];
  logic [WORD_W-1:0] prs_box_x;
  logic [LOST_W-1:0] prs_lost;

  frame_result_t pending_frames [$];

  dual_frame_serial_receiver #(
    .LOST_COUNT_WIDTH(LOST_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .frame_kind(frame_kind),
    .word_first(word_first),
    .word_second(word_second),
    .word_third(word_third),
    .previous_box_x(previous_box_x),
    .lost_count(lost_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit frame_parser_step(input logic [7:0] b, output frame_result_t res);
    logic [WORD_W-1:0] x;
    logic [WORD_W-1:0] y;
    logic [WORD_W-1:0] k;
    bit good;
    res = '0;
    case (prs_phase)
      PH_PAYLOAD: begin
        if (prs_slot < PAYLOAD_LEN) prs_payload[prs_slot] = b;
        if (prs_slot + 1 >= PAYLOAD_LEN) begin
          prs_phase = PH_TAIL;
          prs_slot = 4'(PAYLOAD_LEN);
        end else begin
          prs_slot = prs_slot + 4'd1;
        end
        return 1'b0;
      end
      PH_TAIL: begin
        good = prs_laser ? (b == TAIL_LASER) : (b == TAIL_BOX);
        prs_phase = PH_IDLE;
        prs_slot = '0;
        if (!good) return 1'b0;
        x = {prs_payload[3], prs_payload[2], prs_payload[1], prs_payload[0]};
        y = {prs_payload[7], prs_payload[6], prs_payload[5], prs_payload[4]};
        k = {prs_payload[11], prs_payload[10], prs_payload[9], prs_payload[8]};
        res.kind = prs_laser ? KIND_LASER : KIND_BOX;
        res.x = x;
        res.y = y;
        res.k = k;
        if (prs_laser) begin
          // sign bit ignored, so negative zero counts as lost
          if (x[30:0] == '0 && y[30:0] == '0 && prs_lost != '1) prs_lost = prs_lost + 1'b1;
        end else begin
          res.prev = prs_box_x;
          prs_box_x = x;
        end
        res.lost = LOST_OUT_W'(prs_lost);
        return 1'b1;
      end
      default: begin
        if (b == HDR_BOX) begin
          prs_laser = KIND_BOX;
          prs_phase = PH_PAYLOAD;
          prs_slot = '0;
        end else if (b == HDR_LASER) begin
          prs_laser = KIND_LASER;
          prs_phase = PH_PAYLOAD;
          prs_slot = '0;
        end else begin
          prs_phase = PH_IDLE;
        end
        return 1'b0;
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, output bit fired, output frame_result_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
    fired = frame_parser_step(b, res);
  endtask

  task automatic feed_byte(input logic [7:0] b);
    bit fired;
    frame_result_t res;
    send_byte(b, fired, res);
    if (fired) pending_frames.push_back(res);
  endtask

  task automatic send_frame(input logic laser, input logic [WORD_W-1:0] x,
                            input logic [WORD_W-1:0] y, input logic [WORD_W-1:0] k,
                            input logic [7:0] tail);
    logic [95:0] body;
    body = {k, y, x};
    feed_byte(laser ? HDR_LASER : HDR_BOX);
    for (int i = 0; i < PAYLOAD_LEN; i++) feed_byte(body[8*i +: 8]);
    feed_byte(tail);
    frame_bytes += PAYLOAD_LEN + 2;
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h00000000;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return 32'h7FFFFFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_random_frame();
    int sel;
    logic laser;
    logic [7:0] tail;
    sel = $urandom_range(99);
    laser = 1'($urandom_range(1));
    if (sel < 8) tail = 8'($urandom_range(255));
    else if (sel < 14) tail = laser ? TAIL_BOX : TAIL_LASER;
    else tail = laser ? TAIL_LASER : TAIL_BOX;
    send_frame(laser, pick_word(), pick_word(), $urandom(), tail);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic flag_mismatch(input string what, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) $display("%s: expected %h, got %h", what, want, got);
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin : result_check
    frame_result_t want;
    if (out_valid === 1'b1 && out_ready === 1'b1) begin
      if (frame_kind == KIND_LASER) laser_seen++;
      else box_seen++;
      if (pending_frames.size() == 0) begin
        flag_mismatch("result with no frame pending, word_first", '0, word_first);
      end else begin
        want = pending_frames.pop_front();
        if (want.kind !== frame_kind)
          flag_mismatch("frame_kind", WORD_W'(want.kind), WORD_W'(frame_kind));
        if (want.x !== word_first) flag_mismatch("word_first", want.x, word_first);
        if (want.y !== word_second) flag_mismatch("word_second", want.y, word_second);
        if (want.k !== word_third) flag_mismatch("word_third", want.k, word_third);
        if (want.prev !== previous_box_x)
          flag_mismatch("previous_box_x", want.prev, previous_box_x);
        if (want.lost !== lost_count)
          flag_mismatch("lost_count", WORD_W'(want.lost), WORD_W'(lost_count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               pending_frames.size());
      $display("dual_frame_serial_receiver: mismatch");
      $finish;
    end
  end

  initial begin
    bit fired;
    frame_result_t res;
    in_valid <= 1'b0;
    rx_byte <= 8'h00;
    rst <= 1'b1;
    prs_phase = PH_IDLE;
    prs_laser = KIND_BOX;
    prs_slot = '0;
    prs_box_x = '0;
    prs_lost = '0;
    foreach (prs_payload[i]) prs_payload[i] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < $size(DIRECTED); r++) begin
      feed_byte(DIRECTED[r].lead);
      feed_byte(DIRECTED[r].head);
      for (int i = 0; i < PAYLOAD_LEN; i++) feed_byte(DIRECTED[r].body[8*i +: 8]);
      send_byte(DIRECTED[r].tail, fired, res);
      if (DIRECTED[r].typed) begin
        if (DIRECTED[r].fires) pending_frames.push_back(DIRECTED[r].want);
      end else if (fired) begin
        pending_frames.push_back(res);
      end
    end
    settle();

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      if (p == 0) hold_left = HOLD_CYCLES;
      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES / 4) begin
        if ($urandom_range(99) < 15)
          repeat ($urandom_range(1, 3)) feed_byte(8'($urandom_range(255)));
        else send_random_frame();
      end
      settle();
    end

    // run of lost laser frames, zero and negative zero
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (LOST_FRAMES)
      send_frame(KIND_LASER, $urandom_range(1) ? 32'h80000000 : 32'h00000000,
                 $urandom_range(1) ? 32'h80000000 : 32'h00000000, $urandom(), TAIL_LASER);
    send_random_frame();
    settle();

    $display("covered %0d bytes in, %0d box and %0d laser results checked over four idle mixes,",
             bytes_sent, box_seen, laser_seen);
    $display("a %0d-cycle output hold-off and the lost counter ending at %0d; %0d mismatches",
             HOLD_CYCLES, prs_lost, mismatches);
    if (mismatches == 0) begin
      $display("dual_frame_serial_receiver: match");
    end else begin
      $display("dual_frame_serial_receiver: mismatch");
    end
    $finish;
  end

endmodule
